### src/mexp_pkg.sv
// shared types and constants for the modular exponentiation block
`timescale 1ns / 1ps

package mexp_pkg;

  localparam int WIDTH = 32;
  // modulus width: a zero modulus stands for 2^WIDTH
  localparam int MW    = WIDTH + 1;
  // width of the partial sum 2r + b before reduction
  localparam int TW    = WIDTH + 3;
  localparam int CNT_W = $clog2(WIDTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RED,
    ST_STEP,
    ST_MUL,
    ST_SQR,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic             start;
    logic [WIDTH-1:0] a;
    logic [MW-1:0]    b;
    logic [MW-1:0]    m;
  } mm_req_t;

  typedef struct packed {
    logic          done;
    logic [MW-1:0] res;
  } mm_rsp_t;

endpackage

### src/modular_exponentiation.sv
// modular exponentiation top level: square-and-multiply sequencer around a shared mulmod
`timescale 1ns / 1ps

// channel   direction  signals                         role
// in_       input      in_valid in_ready in_base       base and exponent, one beat per item
//                      in_exponent
// out_      output     out_valid out_ready out_result  base^exponent mod modulus
// cfg_      input      cfg_we cfg_wdata                modulus register write, no read-back
//
// one beat takes one modular multiply to reduce the base, then one multiply per set
// exponent bit and one squaring per bit below the top set bit, all on the single
// bit-serial mulmod unit, plus a pass through the step state for each exponent bit up
// to the top set bit, and the accept and hand-off states
// a zero exponent skips the mulmod unit and gives result 1
// synchronous active-low reset sets the modulus to all ones and empties the output
// in_ready is high only while the sequencer is idle; a finished result waits in the
// sequencer until the output register is free, and out_result holds while stalled

module modular_exponentiation (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [mexp_pkg::WIDTH-1:0] in_base,
  input  logic [mexp_pkg::WIDTH-1:0] in_exponent,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [mexp_pkg::WIDTH-1:0] out_result,
  input  logic                       cfg_we,
  input  logic [mexp_pkg::WIDTH-1:0] cfg_wdata
);

  mexp_pkg::state_t           state_r, state_nxt;
  logic [mexp_pkg::WIDTH-1:0] mod_r;
  logic [mexp_pkg::WIDTH-1:0] exp_r, exp_nxt;
  logic [mexp_pkg::MW-1:0]    acc_r, acc_nxt;
  logic [mexp_pkg::MW-1:0]    sq_r, sq_nxt;
  logic [mexp_pkg::WIDTH-1:0] out_r, out_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [mexp_pkg::MW-1:0]    m_eff;
  logic [mexp_pkg::MW-1:0]    one_red;
  logic [mexp_pkg::WIDTH-1:0] exp_shift;
  logic                       accept;
  logic                       out_free;
  mexp_pkg::mm_req_t          req;
  mexp_pkg::mm_rsp_t          rsp;

  // zero modulus means 2^WIDTH
  assign m_eff     = {(mod_r == '0), mod_r};
  // 1 reduced by the modulus, used to reduce the raw base
  assign one_red   = (m_eff == mexp_pkg::MW'(1)) ? '0 : mexp_pkg::MW'(1);
  assign exp_shift = {1'b0, exp_r[mexp_pkg::WIDTH-1:1]};
  assign in_ready  = (state_r == mexp_pkg::ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  mexp_mulmod u_mulmod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mexp_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_exponent == '0) ? mexp_pkg::ST_FIN : mexp_pkg::ST_RED;
        end
      end
      mexp_pkg::ST_RED: begin
        if (rsp.done) state_nxt = mexp_pkg::ST_STEP;
      end
      mexp_pkg::ST_STEP: begin
        state_nxt = exp_r[0] ? mexp_pkg::ST_MUL : mexp_pkg::ST_SQR;
      end
      mexp_pkg::ST_MUL: begin
        if (rsp.done) begin
          state_nxt = (exp_shift != '0) ? mexp_pkg::ST_SQR : mexp_pkg::ST_FIN;
        end
      end
      mexp_pkg::ST_SQR: begin
        if (rsp.done) state_nxt = mexp_pkg::ST_STEP;
      end
      mexp_pkg::ST_FIN: begin
        if (out_free) state_nxt = mexp_pkg::ST_IDLE;
      end
      default: state_nxt = mexp_pkg::ST_IDLE;
    endcase
  end

  // datapath and mulmod requests
  always_comb begin
    req.start     = 1'b0;
    req.a         = acc_r[mexp_pkg::WIDTH-1:0];
    req.b         = sq_r;
    req.m         = m_eff;
    exp_nxt       = exp_r;
    acc_nxt       = acc_r;
    sq_nxt        = sq_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    unique case (state_r)
      mexp_pkg::ST_IDLE: begin
        if (accept) begin
          exp_nxt = in_exponent;
          acc_nxt = mexp_pkg::MW'(1);
          if (in_exponent != '0) begin
            req.start = 1'b1;
            req.a     = in_base;
            req.b     = one_red;
          end
        end
      end
      mexp_pkg::ST_RED: begin
        if (rsp.done) sq_nxt = rsp.res;
      end
      mexp_pkg::ST_STEP: begin
        req.start = 1'b1;
        if (exp_r[0]) begin
          // acc * sq
          req.a = acc_r[mexp_pkg::WIDTH-1:0];
        end else begin
          // even bit: square only
          exp_nxt = exp_shift;
          req.a   = sq_r[mexp_pkg::WIDTH-1:0];
        end
      end
      mexp_pkg::ST_MUL: begin
        if (rsp.done) begin
          acc_nxt = rsp.res;
          exp_nxt = exp_shift;
          if (exp_shift != '0) begin
            req.start = 1'b1;
            req.a     = sq_r[mexp_pkg::WIDTH-1:0];
          end
        end
      end
      mexp_pkg::ST_SQR: begin
        if (rsp.done) sq_nxt = rsp.res;
      end
      mexp_pkg::ST_FIN: begin
        if (out_free) begin
          out_nxt       = acc_r[mexp_pkg::WIDTH-1:0];
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mexp_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      mod_r       <= '1;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) mod_r <= cfg_wdata;
    end
    exp_r <= exp_nxt;
    acc_r <= acc_nxt;
    sq_r  <= sq_nxt;
    out_r <= out_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_r;

endmodule

### src/mexp_mulmod.sv
// bit-serial interleaved modular multiplier, one bit of a per cycle
`timescale 1ns / 1ps

module mexp_mulmod (
  input  logic              clk,
  input  logic              rst_n,
  input  mexp_pkg::mm_req_t req,
  output mexp_pkg::mm_rsp_t rsp
);

  logic                               busy_r, busy_nxt;
  logic                               done_r, done_nxt;
  logic [mexp_pkg::CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [mexp_pkg::WIDTH-1:0]         a_r, a_nxt;
  logic [mexp_pkg::MW-1:0]            b_r, b_nxt;
  logic [mexp_pkg::MW-1:0]            r_r, r_nxt;
  logic [mexp_pkg::TW-1:0]            t;
  logic [mexp_pkg::TW:0]              d1;
  logic [mexp_pkg::TW:0]              d2;
  logic [mexp_pkg::MW-1:0]            r_step;

  // t = 2r + bit*b, below 3m; pick t, t-m or t-2m
  always_comb begin
    t  = {1'b0, r_r, 1'b0} + (a_r[mexp_pkg::WIDTH-1] ? {2'b00, b_r} : '0);
    d1 = {1'b0, t} - {3'b000, req.m};
    d2 = {1'b0, t} - {2'b00, req.m, 1'b0};
    if (!d2[mexp_pkg::TW]) begin
      r_step = d2[mexp_pkg::MW-1:0];
    end else if (!d1[mexp_pkg::TW]) begin
      r_step = d1[mexp_pkg::MW-1:0];
    end else begin
      r_step = t[mexp_pkg::MW-1:0];
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    r_nxt    = r_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = mexp_pkg::CNT_W'(mexp_pkg::WIDTH - 1);
      a_nxt    = req.a;
      b_nxt    = req.b;
      r_nxt    = '0;
    end else if (busy_r) begin
      a_nxt   = {a_r[mexp_pkg::WIDTH-2:0], 1'b0};
      r_nxt   = r_step;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    r_r   <= r_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.res  = r_r;

endmodule

### verif/mexp_checker.sv
// result checker for the modular exponentiation block: predicts each result and compares
`timescale 1ns / 1ps

module mexp_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [mexp_pkg::WIDTH-1:0] in_base,
  input  logic [mexp_pkg::WIDTH-1:0] in_exponent,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [mexp_pkg::WIDTH-1:0] out_result,
  input  logic                       cfg_we,
  input  logic [mexp_pkg::WIDTH-1:0] cfg_wdata,
  output int unsigned                pending,
  output int unsigned                err_count
);

  typedef logic [mexp_pkg::WIDTH-1:0] word_t;

  word_t modulus_q;
  word_t want_results[$];

  // square-and-multiply from the low exponent bit, products kept at 64 bits
  function automatic word_t pow_mod(word_t b, word_t e, word_t m_reg);
    bit [63:0] m;
    bit [63:0] acc;
    bit [63:0] sq;
    word_t     rest;
    if (e == '0) begin
      return word_t'(1);
    end
    // zero modulus means 2^WIDTH
    m    = (m_reg == '0) ? (64'd1 << mexp_pkg::WIDTH) : 64'(m_reg);
    acc  = 64'd1;
    sq   = 64'(b);
    rest = e;
    while (rest != '0) begin
      if (rest[0]) begin
        acc = (acc * sq) % m;
      end
      rest = rest >> 1;
      if (rest != '0) begin
        sq = (sq * sq) % m;
      end
    end
    return acc[mexp_pkg::WIDTH-1:0];
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      modulus_q = '1;
      err_count = 0;
      want_results.delete();
    end else begin
      if (cfg_we) begin
        modulus_q = cfg_wdata;
      end
      if (out_valid && out_ready) begin
        if (want_results.size() == 0) begin
          $error("result beat with nothing expected: result %0h", out_result);
          err_count = err_count + 1;
        end else begin
          word_t want;
          want = want_results[0];
          want_results.delete(0);
          if (out_result !== want) begin
            $error("result mismatch: expected %0h, actual %0h", want, out_result);
            err_count = err_count + 1;
          end
        end
      end
      if (in_valid && in_ready) begin
        want_results = {want_results, pow_mod(in_base, in_exponent, modulus_q)};
      end
    end
    pending = want_results.size();
  end

endmodule

### verif/tb.sv
// testbench top for the modular exponentiation block: stimulus, flow control and verdict
`timescale 1ns / 1ps

module tb;

  typedef logic [mexp_pkg::WIDTH-1:0] word_t;

  // receiver hold-off length; two results fill the block
  localparam int HOLD_CYCLES = 5000;
  // every beat of a batch before the modulus changes
  localparam int BATCH_ITEMS = 105;
  localparam int BATCHES     = 6;

  logic  clk;
  logic  rst_n       = 1'b0;
  logic  in_valid    = 1'b0;
  logic  in_ready;
  word_t in_base     = '0;
  word_t in_exponent = '0;
  logic  out_valid;
  logic  out_ready   = 1'b0;
  word_t out_result;
  logic  cfg_we      = 1'b0;
  word_t cfg_wdata   = '0;

  // idle rates in percent, changed per phase
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  logic hold_go  = 1'b0;
  logic hold_out = 1'b0;

  int unsigned pending;
  int unsigned err_count;

  modular_exponentiation dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_base     (in_base),
    .in_exponent (in_exponent),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_result  (out_result),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata)
  );

  mexp_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_base     (in_base),
    .in_exponent (in_exponent),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_result  (out_result),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .pending     (pending),
    .err_count   (err_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver side: random stalls, plus the long hold-off when it is active
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !hold_out && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // long receiver stall, counted here so the sender keeps offering beats
  // and the block backs up into in_ready
  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_out <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_out <= 1'b0;
  end

  // offer one beat; valid stays up with a fixed payload until in_ready is seen
  // at an edge; valid is only dropped when the sender decides to idle
  task automatic push_item(input word_t b, input word_t e);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid    <= 1'b1;
    in_base     <= b;
    in_exponent <= e;
    do @(posedge clk); while (!in_ready);
  endtask

  // drop valid and wait until every expected result has come back, so the
  // block is idle and the modulus may change
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // single-cycle register write, only called with the block idle
  task automatic write_modulus(input word_t m);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // one idling phase: several batches, each under a fresh modulus
  task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct,
                           input bit with_hold);
    word_t       m;
    word_t       b;
    word_t       e;
    int unsigned pick;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int bt = 0; bt < BATCHES; bt++) begin
      wait_drained();
      case ($urandom_range(7)) inside
        0:       m = word_t'(1);
        1:       m = word_t'($urandom_range(1000, 2));
        [2:3]:   m = word_t'($urandom);
        4:       m = '1;
        5:       m = word_t'($urandom) | word_t'(32'h8000_0000);
        6:       m = '0;    // wraps at 2^WIDTH
        default: m = word_t'($urandom_range(65535, 2));
      endcase
      write_modulus(m);
      if (with_hold && bt == 0) begin
        hold_go <= 1'b1;
      end
      for (int i = 0; i < BATCH_ITEMS; i++) begin
        case ($urandom_range(9))
          0:       b = '0;
          1:       b = word_t'(1);
          2:       b = '1;
          3:       b = word_t'($urandom_range(255, 2));
          default: b = word_t'($urandom);
        endcase
        // mostly short exponents, since every exponent bit costs block cycles;
        // a tenth use the full width so every bit toggles
        pick = $urandom_range(99);
        if (pick < 5) begin
          e = '0;
        end else if (pick < 70) begin
          e = word_t'($urandom_range(255, 1));
        end else if (pick < 90) begin
          e = word_t'($urandom_range(65535, 256));
        end else begin
          e = word_t'($urandom);
        end
        push_item(b, e);
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, reset modulus of all ones, no idling
    push_item('0, '0);                              // zero exponent gives 1
    push_item('1, '0);
    push_item('0, word_t'(5));
    push_item(word_t'(1), '1);
    push_item('1, word_t'(1));                      // unreduced base, reduces to 0
    push_item('1, '1);
    push_item(word_t'(2), word_t'(31));
    push_item(word_t'(2), word_t'(32));
    push_item(word_t'(3), word_t'(32'h8000_0000));
    push_item(word_t'(32'hFFFF_FFFE), word_t'(2));
    push_item(word_t'(12345), word_t'(65537));

    // modulus of one: zero exponent still gives 1, anything else 0
    wait_drained();
    write_modulus(word_t'(1));
    push_item(word_t'(7), '0);
    push_item(word_t'(7), word_t'(3));
    push_item('0, '0);

    // zero modulus: plain power wrapped to the word width
    wait_drained();
    write_modulus('0);
    push_item(word_t'(3), word_t'(20));
    push_item(word_t'(2), word_t'(31));
    push_item(word_t'(2), word_t'(32));
    push_item('1, '1);
    push_item(word_t'(32'h0001_0001), '1);

    // small modulus with a base well above it
    wait_drained();
    write_modulus(word_t'(13));
    push_item(word_t'(100), word_t'(1));
    push_item(word_t'(5), word_t'(12));
    push_item('1, word_t'(32'h5555_5555));

    // random part: receiver idles more, then sender idles more, then no idling
    // with the long receiver hold-off at the start
    run_phase(31, 75, 1'b0);
    run_phase(75, 31, 1'b0);
    run_phase(0, 0, 1'b1);

    wait_drained();
    repeat (100) @(posedge clk);
    if (err_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // run limit, several times the slowest legal run
  initial begin
    #200_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### files.f
src/mexp_pkg.sv
src/mexp_mulmod.sv
src/modular_exponentiation.sv
verif/mexp_checker.sv
verif/tb.sv
